[sv/spm_pkg.sv]
// Package for the skinning matrix palette: constants, types and fixed-point helpers.
package spm_pkg;

  localparam int MAX_BONE_COUNT_DEF = 64;
  localparam int ELEMS_PER_BONE = 16;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Quaternion product slots, each a Q2.28 value.
  localparam int QP_XX = 0;
  localparam int QP_YY = 1;
  localparam int QP_ZZ = 2;
  localparam int QP_XY = 3;
  localparam int QP_XZ = 4;
  localparam int QP_YZ = 5;
  localparam int QP_WX = 6;
  localparam int QP_WY = 7;
  localparam int QP_WZ = 8;
  localparam int QP_COUNT = 9;

  typedef logic [QP_COUNT-1:0][31:0] quat_prod_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
  } spm_mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // One element of the local matrix, column-major.
  function automatic logic signed [31:0] local_elem(input logic [3:0] idx,
                                                    input quat_prod_t qp,
                                                    input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
    logic signed [32:0] s;
    logic signed [32:0] sh;
    logic signed [33:0] d;
    logic diag;
    logic fixed;
    logic signed [31:0] fv;
    logic signed [31:0] r;
    s = '0;
    diag = 1'b0;
    fixed = 1'b0;
    fv = '0;
    case (idx)
      4'd0: begin
        s = 33'($signed(qp[QP_YY])) + 33'($signed(qp[QP_ZZ]));
        diag = 1'b1;
      end
      4'd1: s = 33'($signed(qp[QP_XY])) + 33'($signed(qp[QP_WZ]));
      4'd2: s = 33'($signed(qp[QP_XZ])) - 33'($signed(qp[QP_WY]));
      4'd4: s = 33'($signed(qp[QP_XY])) - 33'($signed(qp[QP_WZ]));
      4'd5: begin
        s = 33'($signed(qp[QP_XX])) + 33'($signed(qp[QP_ZZ]));
        diag = 1'b1;
      end
      4'd6: s = 33'($signed(qp[QP_YZ])) + 33'($signed(qp[QP_WX]));
      4'd8: s = 33'($signed(qp[QP_XZ])) + 33'($signed(qp[QP_WY]));
      4'd9: s = 33'($signed(qp[QP_YZ])) - 33'($signed(qp[QP_WX]));
      4'd10: begin
        s = 33'($signed(qp[QP_XX])) + 33'($signed(qp[QP_YY]));
        diag = 1'b1;
      end
      4'd12: begin
        fixed = 1'b1;
        fv = px;
      end
      4'd13: begin
        fixed = 1'b1;
        fv = py;
      end
      4'd14: begin
        fixed = 1'b1;
        fv = pz;
      end
      4'd15: begin
        fixed = 1'b1;
        fv = ONE_Q16;
      end
      default: begin
        fixed = 1'b1;
        fv = '0;
      end
    endcase
    sh = s >>> 11;
    if (diag) begin
      d = 34'(ONE_Q16) - 34'(sh);
    end else begin
      d = 34'(sh);
    end
    if (fixed) begin
      r = fv;
    end else begin
      r = sat32(50'(d));
    end
    return r;
  endfunction

endpackage

[sv/spm_chan_if.sv]
// Handshake channel interfaces for the input items and the result items.
interface spm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         bone_index;
  logic signed [6:0]  parent_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic [3:0]         bind_element_index;
  logic signed [31:0] bind_element_value;

  modport source (output valid, mode, bone_index, parent_index, pos_x, pos_y, pos_z,
                  quat_x, quat_y, quat_z, quat_w, bind_element_index,
                  bind_element_value, input ready);
  modport sink (input valid, mode, bone_index, parent_index, pos_x, pos_y, pos_z,
                quat_x, quat_y, quat_z, quat_w, bind_element_index,
                bind_element_value, output ready);
endinterface

interface spm_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_bone_index;
  logic [3:0]         out_element_index;
  logic signed [31:0] matrix_element;
  logic               last_of_bone;

  modport source (output valid, out_bone_index, out_element_index, matrix_element,
                  last_of_bone, input ready);
  modport sink (input valid, out_bone_index, out_element_index, matrix_element,
                last_of_bone, output ready);
endinterface

[sv/spm_ram.sv]
// Generic simple dual-port RAM with a registered read.
module spm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/spm_mac.sv]
// Shared multiplier with a registered product and a saturating accumulator.
module spm_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spm_pkg::spm_mac_ctl_t ctl,
  input  logic signed [31:0]   opa,
  input  logic signed [31:0]   opb,
  output logic signed [63:0]   product,
  output logic signed [31:0]   acc_sat
);
  import spm_pkg::*;

  logic signed [63:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [49:0] acc_nxt;
  logic signed [47:0] term;

  assign product = 64'(opa) * 64'(opb);
  // Floor shift back to Q16.16.
  assign term = 48'(prod_r >>> 16);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_r + 50'(term);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= product;
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_sat = sat32(acc_r);

endmodule

[sv/skinning_matrix_palette.sv]
// Top level of the skinning matrix palette: sequencer, matrix stores and result register.
//
//  channel  | direction | handshake           | moves
//  ---------+-----------+---------------------+-------------------------------------
//  in_ch    | in        | valid/ready         | one pose or inverse-bind write item
//  out_ch   | out       | valid/ready         | one matrix element item
//  cfg_     | in        | cfg_we, no wait     | apply_inverse_bind bit
//
// An inverse-bind write item is taken without leaving idle. A pose item first forms the
// nine quaternion products, then 16 world elements and 16 emitted elements, each a
// four-term dot product or a copy: in_ch.ready stays low from a pose item until its
// last emitted element has been loaded into the result register.
// The order is set by the one shared 32x32 multiplier and the one read port per store.
// Reset clears the sequencer and the result valid, and sets apply_inverse_bind to 1;
// the stores are not cleared. A stalled result holds the sequencer at that element.
module skinning_matrix_palette #(
  parameter int MaxBoneCount = spm_pkg::MAX_BONE_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  spm_in_if.sink    in_ch,
  spm_out_if.source out_ch,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);
  import spm_pkg::*;

  localparam int Depth = MaxBoneCount * ELEMS_PER_BONE;
  localparam int AddrW = $clog2(Depth);
  localparam int BoneW = AddrW - 4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QMUL = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic               phase_r, phase_nxt;
  logic               root_r, root_nxt;
  logic               apply_r;
  logic [5:0]         bone_r;
  logic signed [6:0]  parent_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  quat_prod_t         qp_r;
  logic [3:0]         q_r, q_nxt;
  logic [3:0]         j_r, j_nxt;
  logic [1:0]         k_r, k_nxt;
  logic               v1_r, v2_r;
  logic [1:0]         k1_r;

  logic               out_valid_r;
  logic [5:0]         out_bone_r;
  logic [3:0]         out_elem_r;
  logic signed [31:0] out_data_r;
  logic               out_last_r;

  logic               in_acc;
  logic               bone_ok;
  logic               copy_w;
  logic [1:0]         last_k;
  logic               out_free;
  logic               out_load;

  logic [BoneW-1:0]   bone_b, parent_b, in_bone_b;
  logic               w_we, i_we;
  logic [AddrW-1:0]   w_waddr, w_raddr, i_waddr, i_raddr;
  logic [31:0]        w_rdata, i_rdata;

  spm_mac_ctl_t       mac_ctl;
  logic signed [31:0] opa, opb;
  logic signed [63:0] product;
  logic signed [31:0] acc_sat;
  logic signed [15:0] qa, qb;

  // Input side: the block only takes an item when the sequencer has finished.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign bone_ok = (int'(in_ch.bone_index) < MaxBoneCount);

  assign bone_b    = BoneW'(bone_r);
  assign parent_b  = BoneW'(parent_r[5:0]);
  assign in_bone_b = BoneW'(in_ch.bone_index);

  // A copy is a single term times one: a root while building the world matrix,
  // or the world matrix emitted without inverse bind.
  assign copy_w = phase_r ? !apply_r : root_r;
  assign last_k = copy_w ? 2'd0 : 2'd3;

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_FIN) && phase_r && out_free;

  // Inverse-bind store: written straight from a write item.
  assign i_we    = in_acc && in_ch.mode && bone_ok;
  assign i_waddr = {in_bone_b, in_ch.bind_element_index};
  assign i_raddr = {bone_b, j_r[3:2], k_r};

  // World store: written at the end of each world element, read for the parent
  // in the first phase and for this bone in the second.
  assign w_we    = (state_r == ST_FIN) && !phase_r;
  assign w_waddr = {bone_b, j_r};
  always_comb begin
    if (!phase_r) begin
      w_raddr = {parent_b, k_r, j_r[1:0]};
    end else if (apply_r) begin
      w_raddr = {bone_b, k_r, j_r[1:0]};
    end else begin
      w_raddr = {bone_b, j_r};
    end
  end

  spm_ram #(.Width(32), .Depth(Depth)) u_world_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (acc_sat),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  spm_ram #(.Width(32), .Depth(Depth)) u_ibind_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (in_ch.bind_element_value),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  // Quaternion operand pairs, one product per cycle.
  always_comb begin
    case (q_r)
      4'd0: begin qa = qx_r; qb = qx_r; end
      4'd1: begin qa = qy_r; qb = qy_r; end
      4'd2: begin qa = qz_r; qb = qz_r; end
      4'd3: begin qa = qx_r; qb = qy_r; end
      4'd4: begin qa = qx_r; qb = qz_r; end
      4'd5: begin qa = qy_r; qb = qz_r; end
      4'd6: begin qa = qw_r; qb = qx_r; end
      4'd7: begin qa = qw_r; qb = qy_r; end
      default: begin qa = qw_r; qb = qz_r; end
    endcase
  end

  // Multiplier operands. Store data arrives in the cycle after its address, tagged k1_r.
  always_comb begin
    if (state_r == ST_QMUL) begin
      opa = 32'(qa);
      opb = 32'(qb);
    end else if (!phase_r) begin
      if (root_r) begin
        opa = local_elem(j_r, qp_r, px_r, py_r, pz_r);
        opb = ONE_Q16;
      end else begin
        opa = $signed(w_rdata);
        opb = local_elem({j_r[3:2], k1_r}, qp_r, px_r, py_r, pz_r);
      end
    end else begin
      opa = $signed(w_rdata);
      opb = apply_r ? $signed(i_rdata) : ONE_Q16;
    end
  end

  assign mac_ctl.clr    = (state_r == ST_RD) && (k_r == 2'd0);
  assign mac_ctl.acc_en = v2_r;

  spm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .opa     (opa),
    .opb     (opb),
    .product (product),
    .acc_sat (acc_sat)
  );

  // Sequencer: products of the quaternion, then per element issue the reads,
  // let the multiply and add drain, then store or emit the element.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    root_nxt  = root_r;
    q_nxt     = q_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_ch.mode && bone_ok) begin
          state_nxt = ST_QMUL;
          q_nxt     = '0;
          root_nxt  = in_ch.parent_index[6] ||
                      (in_ch.parent_index[5:0] >= in_ch.bone_index);
        end
      end
      ST_QMUL: begin
        q_nxt = q_r + 4'd1;
        if (q_r == 4'(QP_COUNT - 1)) begin
          state_nxt = ST_RD;
          phase_nxt = 1'b0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RD: begin
        if (k_r == last_k) begin
          state_nxt = ST_WAIT;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_WAIT: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!phase_r || out_free) begin
          j_nxt = j_r + 4'd1;
          if (j_r == 4'd15) begin
            if (phase_r) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_RD;
              phase_nxt = 1'b1;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      root_r      <= 1'b0;
      apply_r     <= 1'b1;
      q_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      k1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      root_r  <= root_nxt;
      q_r     <= q_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      v1_r    <= (state_r == ST_RD);
      v2_r    <= v1_r;
      k1_r    <= k_r;
      if (cfg_we) begin
        apply_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && !in_ch.mode) begin
      bone_r   <= in_ch.bone_index;
      parent_r <= in_ch.parent_index;
      px_r     <= in_ch.pos_x;
      py_r     <= in_ch.pos_y;
      pz_r     <= in_ch.pos_z;
      qx_r     <= in_ch.quat_x;
      qy_r     <= in_ch.quat_y;
      qz_r     <= in_ch.quat_z;
      qw_r     <= in_ch.quat_w;
    end
    if (state_r == ST_QMUL) begin
      qp_r[q_r] <= product[31:0];
    end
    if (out_load) begin
      out_bone_r <= bone_r;
      out_elem_r <= j_r;
      out_data_r <= acc_sat;
      out_last_r <= (j_r == 4'd15);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_bone_index    = out_bone_r;
  assign out_ch.out_element_index = out_elem_r;
  assign out_ch.matrix_element    = out_data_r;
  assign out_ch.last_of_bone      = out_last_r;

`ifndef SYNTHESIS
  // The product stage is only ever valid when the read data stage was valid the cycle before.
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("product stage valid without a preceding read");

  // A parent read never hits the entry being written.
  a_parent_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD && !phase_r && !root_r) |-> (parent_r[5:0] < bone_r))
    else $error("parent read from an entry not below the bone");

  // The last emitted element of a bone returns the sequencer to idle.
  a_bone_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && j_r == 4'd15) |=> (state_r == ST_IDLE))
    else $error("sequencer did not finish after the last element");

  // The last flag marks element fifteen only.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_elem_r == 4'd15)))
    else $error("last flag out of step with the element index");
`endif

endmodule

[tb/spm_checker.sv]
// Checker for the skinning matrix palette: predicts matrix elements and compares results.
module spm_checker (
  input  logic clk,
  input  logic rst_n,
  spm_in_if    in_ch,
  spm_out_if   out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef int mat_t [16];

  typedef struct {
    logic [5:0]  bone;
    logic [3:0]  elem;
    logic [31:0] value;
    logic        last;
  } elem_exp_t;

  int        world_words [spm_pkg::MAX_BONE_COUNT_DEF*16];
  int        bind_words [spm_pkg::MAX_BONE_COUNT_DEF*16];
  logic      use_bind;
  elem_exp_t elem_q[$];

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic mat_t mat_product(input mat_t a, input mat_t b);
    mat_t   o;
    longint acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          acc += (longint'(a[k*4+r]) * longint'(b[c*4+k])) >>> 16;
        end
        o[c*4+r] = clamp32(acc);
      end
    end
    return o;
  endfunction

  // Rotation from Q1.14 products (Q2.28), doubled by the shift of 11.
  function automatic mat_t pose_matrix(input logic signed [15:0] x, y, z, w,
                                       input logic signed [31:0] px, py, pz);
    mat_t   m;
    longint qx, qy, qz, qw;
    qx = x; qy = y; qz = z; qw = w;
    m[0]  = clamp32(65536 - ((qy*qy + qz*qz) >>> 11));
    m[1]  = clamp32((qx*qy + qw*qz) >>> 11);
    m[2]  = clamp32((qx*qz - qw*qy) >>> 11);
    m[3]  = 0;
    m[4]  = clamp32((qx*qy - qw*qz) >>> 11);
    m[5]  = clamp32(65536 - ((qx*qx + qz*qz) >>> 11));
    m[6]  = clamp32((qy*qz + qw*qx) >>> 11);
    m[7]  = 0;
    m[8]  = clamp32((qx*qz + qw*qy) >>> 11);
    m[9]  = clamp32((qy*qz - qw*qx) >>> 11);
    m[10] = clamp32(65536 - ((qx*qx + qy*qy) >>> 11));
    m[11] = 0;
    m[12] = px;
    m[13] = py;
    m[14] = pz;
    m[15] = 65536;
    return m;
  endfunction

  always @(posedge clk) begin
    mat_t      loc, wld, par, ib, emit;
    elem_exp_t e;
    int        b;
    if (!rst_n) begin
      use_bind   <= 1'b1;
      fail_count <= 0;
      elem_q.delete();
    end else begin
      if (cfg_we) use_bind <= cfg_wdata;

      if (in_ch.valid && in_ch.ready) begin
        b = in_ch.bone_index;
        if (in_ch.mode) begin
          bind_words[b*16 + in_ch.bind_element_index] = in_ch.bind_element_value;
        end else begin
          loc = pose_matrix(in_ch.quat_x, in_ch.quat_y, in_ch.quat_z, in_ch.quat_w,
                            in_ch.pos_x, in_ch.pos_y, in_ch.pos_z);
          if (in_ch.parent_index < 0 || in_ch.parent_index >= $signed({1'b0, in_ch.bone_index})) begin
            wld = loc;
          end else begin
            for (int k = 0; k < 16; k++) par[k] = world_words[in_ch.parent_index*16 + k];
            wld = mat_product(par, loc);
          end
          for (int k = 0; k < 16; k++) begin
            world_words[b*16 + k] = wld[k];
            ib[k] = bind_words[b*16 + k];
          end
          emit = use_bind ? mat_product(wld, ib) : wld;
          for (int k = 0; k < 16; k++) begin
            e.bone = 6'(b); e.elem = 4'(k); e.value = emit[k]; e.last = (k == 15);
            elem_q = {elem_q, e};
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (elem_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item bone %0d element %0d",
                                        out_ch.out_bone_index, out_ch.out_element_index);
          fail_count <= fail_count + 1;
        end else begin
          e = elem_q.pop_front();
          if (out_ch.out_bone_index !== e.bone || out_ch.out_element_index !== e.elem ||
              out_ch.matrix_element !== e.value || out_ch.last_of_bone !== e.last) begin
            if (fail_count < 10)
              $display("mismatch: exp bone %0d elem %0d val %h last %b, got %0d %0d %h %b",
                       e.bone, e.elem, e.value, e.last, out_ch.out_bone_index,
                       out_ch.out_element_index, out_ch.matrix_element, out_ch.last_of_bone);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= elem_q.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the skinning matrix palette: stimulus, idling and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 300;
  localparam int ItemCount = 270;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending;
  int   sent_items;

  // Stimulus bookkeeping: which inverse-bind elements and world matrices exist.
  logic [15:0] bind_mask [64];
  logic        world_done [64];
  logic        apply_bit;
  logic        calm;

  typedef struct {
    logic               mode;
    logic [5:0]         bone;
    logic signed [6:0]  parent;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qx, qy, qz, qw;
    logic [3:0]         be;
    logic signed [31:0] bv;
  } pose_item_t;

  spm_in_if  in_ch ();
  spm_out_if out_ch ();

  skinning_matrix_palette dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  spm_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls with a chance of 13 in a hundred, except in the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_pos();
    if ($urandom_range(1)) return $urandom;
    return $signed($urandom_range(2097152)) - 32'sd1048576;
  endfunction

  function automatic logic signed [15:0] rand_quat_part();
    case ($urandom_range(3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return $signed(16'($urandom_range(16000))) - 16'sd8000;
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  // Fills every field with noise; the caller then sets the ones that matter.
  function automatic pose_item_t noise_item();
    pose_item_t it;
    it.mode = 1'b0;
    it.bone = $urandom;
    it.parent = $urandom;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.qx = rand_quat_part(); it.qy = rand_quat_part();
    it.qz = rand_quat_part(); it.qw = rand_quat_part();
    it.be = $urandom;
    it.bv = $urandom;
    return it;
  endfunction

  task automatic send_item(input pose_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid              <= 1'b1;
    in_ch.mode               <= it.mode;
    in_ch.bone_index         <= it.bone;
    in_ch.parent_index       <= it.parent;
    in_ch.pos_x              <= it.px;
    in_ch.pos_y              <= it.py;
    in_ch.pos_z              <= it.pz;
    in_ch.quat_x             <= it.qx;
    in_ch.quat_y             <= it.qy;
    in_ch.quat_z             <= it.qz;
    in_ch.quat_w             <= it.qw;
    in_ch.bind_element_index <= it.be;
    in_ch.bind_element_value <= it.bv;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic write_bind(input logic [5:0] bone, input logic [3:0] e,
                            input logic signed [31:0] v);
    pose_item_t it;
    it = noise_item();
    it.mode = 1'b1; it.bone = bone; it.be = e; it.bv = v;
    send_item(it);
    bind_mask[bone][e] = 1'b1;
  endtask

  // Inverse-bind values near identity mostly, with some large and random ones.
  function automatic logic signed [31:0] rand_bind(input int e);
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(262144)) - 32'sd131072;
      default: return ((e % 5) == 0 ? 32'sd65536 : 32'sd0) +
                      $signed($urandom_range(8192)) - 32'sd4096;
    endcase
  endfunction

  // Poses a bone; with the inverse bind applied, its missing elements are written first
  // so that the block never reads a store entry that was never written.
  task automatic pose_bone(input pose_item_t it);
    if (apply_bit) begin
      for (int e = 0; e < 16; e++) begin
        if (!bind_mask[it.bone][e]) write_bind(it.bone, e, rand_bind(e));
      end
    end
    it.mode = 1'b0;
    send_item(it);
    world_done[it.bone] = 1'b1;
  endtask

  function automatic logic signed [6:0] pick_parent(input logic [5:0] bone);
    int p;
    int r;
    r = $urandom_range(9);
    if (r < 2) return -7'sd1;
    if (r < 3) return $signed(7'($urandom_range(63, bone)));
    if (r < 4) return $signed(7'($urandom_range(127, 64)));
    for (int t = 0; t < 8 && bone > 0; t++) begin
      p = $urandom_range(bone - 1);
      if (world_done[p]) return 7'(p);
    end
    return -7'sd1;
  endfunction

  // Configuration only changes once every expected result has come out and the
  // block has had time to finish any inverse-bind write.
  task automatic set_apply(input logic v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_bit = v;
  endtask

  initial begin
    pose_item_t it;
    int bone;
    int phase_n;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.bone_index = '0;
    in_ch.parent_index = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0; in_ch.quat_w = '0;
    in_ch.bind_element_index = '0;
    in_ch.bind_element_value = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    calm = 1'b0;
    apply_bit = 1'b1;
    sent_items = 0;
    phase_n = 0;
    for (int b = 0; b < 64; b++) begin
      bind_mask[b] = '0;
      world_done[b] = 1'b0;
    end
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Bone 0 gets an exact identity inverse bind except one element
    // at the most negative value, then poses with extreme positions and the identity quaternion.
    for (int e = 0; e < 16; e++)
      write_bind(6'd0, e, (e == 14) ? 32'sh80000000 : ((e % 5) == 0 ? 32'sd65536 : 32'sd0));
    it = noise_item();
    it.bone = 6'd0; it.parent = -7'sd1;
    it.px = 32'sh7fffffff; it.py = 32'sh80000000; it.pz = 32'sd0;
    it.qx = 16'sd0; it.qy = 16'sd0; it.qz = 16'sd0; it.qw = 16'sd16384;
    pose_bone(it);

    // A non-unit quaternion with every part at 16384 drives the diagonal negative.
    it.bone = 6'd63; it.parent = 7'sd0;
    it.qx = 16'sd16384; it.qy = 16'sd16384; it.qz = 16'sd16384; it.qw = 16'sd16384;
    it.px = 32'sh80000000; it.py = 32'sh7fffffff; it.pz = 32'sh7fffffff;
    pose_bone(it);

    // World matrix emitted alone: parents that count as root and the highest parent below the bone.
    set_apply(1'b0);
    it = noise_item(); it.bone = 6'd5; it.parent = 7'sd7;
    pose_bone(it);
    it = noise_item(); it.bone = 6'd6; it.parent = -7'sd64;
    it.qx = -16'sd16384; it.qy = -16'sd16384; it.qz = -16'sd16384; it.qw = -16'sd16384;
    pose_bone(it);
    it = noise_item(); it.bone = 6'd7; it.parent = 7'sd63;
    pose_bone(it);
    it = noise_item(); it.bone = 6'd8; it.parent = 7'sd7;
    pose_bone(it);
    it = noise_item(); it.bone = 6'd9; it.parent = 7'sd9;
    pose_bone(it);

    // Random part: mostly well-formed poses of chains, with stray inverse-bind writes.
    set_apply(1'b1);
    while (sent_items < ItemCount) begin
      if (phase_n == 0 && sent_items >= 120) begin
        set_apply(1'b0);
        phase_n = 1;
      end
      if (phase_n == 1 && sent_items >= 190) begin
        set_apply(1'b1);
        phase_n = 2;
      end
      calm = (sent_items >= 140 && sent_items < 180);
      it = noise_item();
      if ($urandom_range(99) < 15) begin
        write_bind(it.bone, it.be, rand_bind(it.be));
      end else begin
        bone = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(7);
        it.bone = bone;
        it.parent = pick_parent(it.bone);
        it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos();
        pose_bone(it);
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
